/* sv/ssg_pkg.sv */
`timescale 1ns / 1ps
// Shared types, constants and per-channel arithmetic of the servo setpoint generator.
package ssg_pkg;

  localparam int unsigned NUM_SERVOS = 4;

  // Command codes of an input item
  localparam logic [1:0] CMD_TICK = 2'd0;
  localparam logic [1:0] CMD_MODE = 2'd1;
  localparam logic [1:0] CMD_PAD  = 2'd2;

  // Mode values carried by a mode command
  localparam logic [7:0] MODE_MANUAL = 8'd0;
  localparam logic [7:0] MODE_REMOTE = 8'd1;

  // Register bank select (paddr[4]); paddr[3:2] picks the servo
  localparam logic BANK_MIN = 1'b0;
  localparam logic BANK_MAX = 1'b1;

  localparam logic [7:0] SOFT_START_TICKS = 8'd180;
  localparam logic [9:0] POT_MAX          = 10'd1023;

  // ceil(2^29 / 1023) = 2^19 + 2^9 + 1, exact quotient for products below 2^18
  localparam int unsigned POT_RECIP_SHIFT = 29;
  // ceil(2^37 / 375): |pad| * 65536 / 3000 == (|pad| * PAD_RECIP) >> 24 for |pad| <= 2^15
  localparam logic [28:0] PAD_RECIP = 29'd366503876;

  // Channels whose gamepad axis is inverted
  localparam logic [3:0] POL_NEG = 4'b1010;

  localparam logic [3:0][7:0] INIT_ANGLE = {8'd100, 8'd90, 8'd55, 8'd90};
  localparam logic [3:0][7:0] RESET_MIN  = {8'd100, 8'd180, 8'd55, 8'd0};
  localparam logic [3:0][7:0] RESET_MAX  = {8'd35, 8'd0, 8'd175, 8'd180};

  typedef struct packed {
    logic [1:0]         command;
    logic [15:0]        pot_raw_0;
    logic [15:0]        pot_raw_1;
    logic [15:0]        pot_raw_2;
    logic [15:0]        pot_raw_3;
    logic signed [15:0] pad_0;
    logic signed [15:0] pad_1;
    logic signed [15:0] pad_2;
    logic signed [15:0] pad_3;
    logic [7:0]         mode_value;
  } ssg_in_t;

  typedef struct packed {
    logic [7:0] servo_0;
    logic [7:0] servo_1;
    logic [7:0] servo_2;
    logic [7:0] servo_3;
    logic [9:0] pot_0;
    logic [9:0] pot_1;
    logic [9:0] pot_2;
    logic [9:0] pot_3;
    logic       soft_start_active;
  } ssg_out_t;

  // Saturate a raw potentiometer word to 10 bits
  function automatic logic [9:0] pot_saturate(input logic [15:0] raw);
    return (raw > 16'(POT_MAX)) ? POT_MAX : raw[9:0];
  endfunction

  // lo + trunc(pot * (hi - lo) / 1023), division by reciprocal shift-add
  function automatic logic [7:0] manual_target(input logic [9:0] pot,
                                               input logic [7:0] lo,
                                               input logic [7:0] hi);
    logic [7:0]  span;
    logic [17:0] prod;
    logic [36:0] scaled;
    logic [7:0]  quot;
    span   = (hi < lo) ? (lo - hi) : (hi - lo);
    prod   = {8'b0, pot} * {10'b0, span};
    scaled = ({19'b0, prod} << 19) + ({19'b0, prod} << 9) + {19'b0, prod};
    quot   = scaled[POT_RECIP_SHIFT +: 8];
    return (hi < lo) ? (lo - quot) : (lo + quot);
  endfunction

  // trunc(pad * polarity * 65536 / 3000) in units of 2^-16 degree
  function automatic logic signed [20:0] pad_increment(input logic signed [15:0] pad,
                                                       input logic pol_neg);
    logic [15:0] mag;
    logic [44:0] prod;
    logic [19:0] inc_mag;
    mag     = pad[15] ? (~$unsigned(pad) + 16'd1) : $unsigned(pad);
    prod    = {29'b0, mag} * {16'b0, PAD_RECIP};
    inc_mag = prod[43:24];
    return (pad[15] ^ pol_neg) ? -$signed({1'b0, inc_mag}) : $signed({1'b0, inc_mag});
  endfunction

endpackage

/* sv/servo_setpoint_generator_core.sv */
`timescale 1ns / 1ps
// Top level of the servo setpoint generator: command decode, per-servo targets, result register.
//
// Usage:
//   Input channel (in_valid / in_stall / in_data) carries one item per command:
//   a control tick, a mode change or a set of gamepad axes. Only a tick yields
//   a result item on the output channel (out_valid / out_stall / out_data):
//   four angle setpoints, four saturated potentiometer values and the soft
//   start flag. Mode and gamepad items update internal state silently.
//   The result of an accepted tick is registered and shows in the cycle after
//   acceptance. Throughput: one item per cycle; every calculation
//   (reciprocal divide, clamp, ramp step) fits between the input port and the
//   result register, so the rate is set by the single result register alone.
//   When the receiver stalls with a result waiting, in_stall rises and all
//   state holds until the result is taken.
//   Angle pairs are written over the APB port (byte address 4*i, min bank at 0x00..0x0C,
//   max bank at 0x10..0x1C); the user must write them only while the block is idle (unenforced).
//   Reset (rst, synchronous) restores the default angle pairs, sets all
//   setpoints to their home angles, selects manual mode, clears the gamepad
//   increments and restarts the 180-tick soft start ramp.
module servo_setpoint_generator_core (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_stall,
  input  ssg_pkg::ssg_in_t in_data,
  output logic             out_valid,
  input  logic             out_stall,
  output ssg_pkg::ssg_out_t out_data,
  input  logic             psel,
  input  logic             penable,
  input  logic             pwrite,
  input  logic [4:0]       paddr,
  input  logic [31:0]      pwdata,
  output logic [31:0]      prdata,
  output logic             pready
);
  import ssg_pkg::*;

  // Configuration registers
  logic [7:0] angle_min [NUM_SERVOS];
  logic [7:0] angle_max [NUM_SERVOS];

  // Block state
  logic [7:0]         servo_angle [NUM_SERVOS];
  logic [23:0]        remote_pos  [NUM_SERVOS];
  logic signed [20:0] pad_inc     [NUM_SERVOS];
  logic [7:0]         ss_count;
  logic               ss_flag;
  logic               remote_mode;

  // Next values for a tick
  logic [7:0]         servo_next     [NUM_SERVOS];
  logic [23:0]        remote_pos_next[NUM_SERVOS];
  logic signed [20:0] pad_inc_next   [NUM_SERVOS];
  logic [9:0]         pot_sat        [NUM_SERVOS];
  logic [15:0]        pot_raw        [NUM_SERVOS];
  logic signed [15:0] pad_raw        [NUM_SERVOS];
  logic [7:0]         ss_count_next;
  logic               ss_flag_next;
  logic               ss_count_adv;

  logic accept;
  logic cfg_write;

  // Hold the input side while a finished result waits on a stalled receiver
  assign in_stall = out_valid & out_stall;
  assign accept   = in_valid & ~in_stall;

  assign pready    = 1'b1;
  assign cfg_write = psel & penable & pwrite;

  // ---------------------------------------------------------------------
  // Configuration port
  // ---------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < NUM_SERVOS; i++) begin
        angle_min[i] <= RESET_MIN[i];
        angle_max[i] <= RESET_MAX[i];
      end
    end else if (cfg_write) begin
      if (paddr[4] == BANK_MIN) begin
        angle_min[paddr[3:2]] <= pwdata[7:0];
      end else begin
        angle_max[paddr[3:2]] <= pwdata[7:0];
      end
    end
  end

  always_comb begin
    prdata = 32'b0;
    if (paddr[4] == BANK_MAX) begin
      prdata[7:0] = angle_max[paddr[3:2]];
    end else begin
      prdata[7:0] = angle_min[paddr[3:2]];
    end
  end

  // ---------------------------------------------------------------------
  // Soft start counter: advance once per tick, drop the flag on the last one
  // ---------------------------------------------------------------------
  assign ss_count_adv  = (ss_count < SOFT_START_TICKS);
  assign ss_count_next = ss_count_adv ? (ss_count + 8'd1) : ss_count;
  assign ss_flag_next  = ss_flag & ~(ss_count_adv & (ss_count_next >= SOFT_START_TICKS));

  // ---------------------------------------------------------------------
  // Per-servo target and setpoint
  // ---------------------------------------------------------------------
  assign pot_raw[0] = in_data.pot_raw_0;
  assign pot_raw[1] = in_data.pot_raw_1;
  assign pot_raw[2] = in_data.pot_raw_2;
  assign pot_raw[3] = in_data.pot_raw_3;
  assign pad_raw[0] = in_data.pad_0;
  assign pad_raw[1] = in_data.pad_1;
  assign pad_raw[2] = in_data.pad_2;
  assign pad_raw[3] = in_data.pad_3;

  always_comb begin
    logic [7:0]         lo;
    logic [7:0]         hi;
    logic [7:0]         lower;
    logic [7:0]         upper;
    logic [7:0]         man_tgt;
    logic [7:0]         target;
    logic signed [25:0] sum;
    logic signed [25:0] bound_lo;
    logic signed [25:0] bound_hi;
    logic signed [25:0] clamped;
    for (int i = 0; i < NUM_SERVOS; i++) begin
      lo         = angle_min[i];
      hi         = angle_max[i];
      pot_sat[i] = pot_saturate(pot_raw[i]);
      pad_inc_next[i] = pad_increment(pad_raw[i], POL_NEG[i]);

      // Manual: linear map of the potentiometer onto the angle pair
      man_tgt = manual_target(pot_sat[i], lo, hi);

      // Remote: integrate the gamepad increment and clamp to the angle pair
      lower    = (lo < hi) ? lo : hi;
      upper    = (lo < hi) ? hi : lo;
      sum      = $signed({2'b0, remote_pos[i]}) + $signed({{5{pad_inc[i][20]}}, pad_inc[i]});
      bound_lo = $signed({2'b0, lower, 16'b0});
      bound_hi = $signed({2'b0, upper, 16'b0});
      if (sum < bound_lo) begin
        clamped = bound_lo;
      end else if (sum > bound_hi) begin
        clamped = bound_hi;
      end else begin
        clamped = sum;
      end

      if (remote_mode) begin
        target             = clamped[23:16];
        remote_pos_next[i] = clamped[23:0];
      end else begin
        target             = man_tgt;
        remote_pos_next[i] = {man_tgt, 16'b0};
      end

      // Ramp one degree toward the target during soft start, else jump to it
      if (ss_flag_next) begin
        if (servo_angle[i] < target) begin
          servo_next[i] = servo_angle[i] + 8'd1;
        end else if (servo_angle[i] > target) begin
          servo_next[i] = servo_angle[i] - 8'd1;
        end else begin
          servo_next[i] = servo_angle[i];
        end
      end else begin
        servo_next[i] = target;
      end
    end
  end

  // ---------------------------------------------------------------------
  // State update
  // ---------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < NUM_SERVOS; i++) begin
        servo_angle[i] <= INIT_ANGLE[i];
        remote_pos[i]  <= {INIT_ANGLE[i], 16'b0};
        pad_inc[i]     <= '0;
      end
      ss_count    <= '0;
      ss_flag     <= 1'b1;
      remote_mode <= 1'b0;
    end else if (accept) begin
      unique case (in_data.command)
        CMD_TICK: begin
          ss_count <= ss_count_next;
          ss_flag  <= ss_flag_next;
          for (int i = 0; i < NUM_SERVOS; i++) begin
            servo_angle[i] <= servo_next[i];
            remote_pos[i]  <= remote_pos_next[i];
          end
        end
        CMD_MODE: begin
          if (in_data.mode_value == MODE_MANUAL) begin
            remote_mode <= 1'b0;
            ss_count    <= '0;
            ss_flag     <= 1'b1;
          end else if (in_data.mode_value == MODE_REMOTE) begin
            remote_mode <= 1'b1;
          end
        end
        CMD_PAD: begin
          for (int i = 0; i < NUM_SERVOS; i++) begin
            pad_inc[i] <= pad_inc_next[i];
          end
        end
        default: begin
          // unused command code: no effect
        end
      endcase
    end
  end

  // ---------------------------------------------------------------------
  // Result register: load on an accepted tick, clear once taken
  // ---------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (accept && (in_data.command == CMD_TICK)) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept && (in_data.command == CMD_TICK)) begin
      out_data.servo_0           <= servo_next[0];
      out_data.servo_1           <= servo_next[1];
      out_data.servo_2           <= servo_next[2];
      out_data.servo_3           <= servo_next[3];
      out_data.pot_0             <= pot_sat[0];
      out_data.pot_1             <= pot_sat[1];
      out_data.pot_2             <= pot_sat[2];
      out_data.pot_3             <= pot_sat[3];
      out_data.soft_start_active <= ss_flag_next;
    end
  end

  // ---------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------
  a_count_bounded: assert property (@(posedge clk) disable iff (rst)
    ss_count <= SOFT_START_TICKS)
    else $error("soft start count beyond its limit");

  a_flag_only_at_end: assert property (@(posedge clk) disable iff (rst)
    !ss_flag |-> (ss_count == SOFT_START_TICKS))
    else $error("soft start flag cleared before the ramp completed");

  a_result_from_tick: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(accept && (in_data.command == CMD_TICK)))
    else $error("result item without an accepted tick");

  a_hold_on_stall: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_stall) |=> (out_valid && $stable(out_data) && $stable(ss_count)))
    else $error("result or state changed while the receiver stalled");

endmodule

/* tb/servo_setpoint_generator_core_tb.sv */
`timescale 1ns / 1ps
// Self-checking testbench of servo_setpoint_generator_core with its own setpoint model.
module servo_setpoint_generator_core_tb;
  import ssg_pkg::*;

  // Unused command code: the block must drop such an item without a trace
  localparam logic [1:0] CMD_UNUSED = 2'd3;

  // Model constants, kept apart from the package on purpose
  localparam int RAMP_TICKS  = 180;
  localparam int POT_LIMIT   = 1023;
  localparam int PAD_DIVISOR = 3000;
  localparam longint FRAC_SCALE = 65536;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_stall;
  ssg_in_t     in_data = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  ssg_out_t    out_data;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [4:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  // Idle chances in percent; most tests set them, the others keep the last values
  int send_gap_pct = 0;
  int stall_pct    = 0;
  int fail_count   = 0;

  // Setpoint model state: angle pairs, setpoints, remote positions, held gamepad axes
  logic [7:0]         cfg_lo [4];
  logic [7:0]         cfg_hi [4];
  logic [7:0]         angle_now [4];
  logic [23:0]        remote_pos [4];
  logic signed [15:0] pad_held [4];
  int                 ramp_ticks;
  bit                 ramp_active;
  bit                 remote_on;

  // Results still owed by the block, oldest first
  ssg_out_t pending_setpoints [$];
  ssg_out_t want;

  servo_setpoint_generator_core DUT (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .psel      (psel),
    .penable   (penable),
    .pwrite    (pwrite),
    .paddr     (paddr),
    .pwdata    (pwdata),
    .prdata    (prdata),
    .pready    (pready)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Receiver side: stall at random at the current rate
  always @(negedge clk) begin
    out_stall <= ($urandom_range(99) < stall_pct);
  end

  // ---------------------------------------------------------------------------
  // Setpoint model
  // ---------------------------------------------------------------------------

  task automatic reset_setpoint_model();
    cfg_lo      = '{8'd0, 8'd55, 8'd180, 8'd100};
    cfg_hi      = '{8'd180, 8'd175, 8'd0, 8'd35};
    angle_now   = '{8'd90, 8'd55, 8'd90, 8'd100};
    for (int i = 0; i < 4; i++) begin
      remote_pos[i] = {angle_now[i], 16'h0000};
      pad_held[i]   = '0;
    end
    ramp_ticks  = 0;
    ramp_active = 1'b1;
    remote_on   = 1'b0;
  endtask

  // Advance the model by one accepted item; queue the result a tick produces
  task automatic advance_setpoint_model(input ssg_in_t item);
    logic [15:0]        raw [4];
    logic signed [15:0] pads [4];
    logic [9:0]         sat [4];
    int                 lo, hi, mn, mx, target, pot;
    longint             axis, inc, pos;
    ssg_out_t           res;
    raw  = '{item.pot_raw_0, item.pot_raw_1, item.pot_raw_2, item.pot_raw_3};
    pads = '{item.pad_0, item.pad_1, item.pad_2, item.pad_3};
    case (item.command)
      CMD_MODE: begin
        // Manual mode also restarts the ramp; unlisted values leave everything alone
        if (item.mode_value == MODE_MANUAL) begin
          remote_on   = 1'b0;
          ramp_ticks  = 0;
          ramp_active = 1'b1;
        end else if (item.mode_value == MODE_REMOTE) begin
          remote_on = 1'b1;
        end
      end
      CMD_PAD: begin
        pad_held = pads;
      end
      CMD_TICK: begin
        // The flag drops on the tick that completes the ramp, already for its servos
        if (ramp_ticks < RAMP_TICKS) begin
          ramp_ticks++;
          if (ramp_ticks >= RAMP_TICKS) ramp_active = 1'b0;
        end
        for (int i = 0; i < 4; i++) begin
          pot    = (raw[i] > POT_LIMIT) ? POT_LIMIT : int'(raw[i]);
          sat[i] = 10'(pot);
          lo     = int'(cfg_lo[i]);
          hi     = int'(cfg_hi[i]);
          if (remote_on) begin
            // Odd channels have an inverted axis; the step truncates toward zero
            mn   = (lo < hi) ? lo : hi;
            mx   = (lo < hi) ? hi : lo;
            axis = longint'(pad_held[i]) * ((i % 2) ? -1 : 1);
            inc  = (axis * FRAC_SCALE) / PAD_DIVISOR;
            pos  = longint'(remote_pos[i]) + inc;
            if (pos < longint'(mn) * FRAC_SCALE) pos = longint'(mn) * FRAC_SCALE;
            if (pos > longint'(mx) * FRAC_SCALE) pos = longint'(mx) * FRAC_SCALE;
            remote_pos[i] = pos[23:0];
            target = int'(remote_pos[i][23:16]);
          end else begin
            target = lo + (pot * (hi - lo)) / POT_LIMIT;
            remote_pos[i] = {8'(target), 16'h0000};
          end
          if (ramp_active) begin
            if (int'(angle_now[i]) < target) angle_now[i]++;
            else if (int'(angle_now[i]) > target) angle_now[i]--;
          end else begin
            angle_now[i] = 8'(target);
          end
        end
        res.servo_0 = angle_now[0];
        res.servo_1 = angle_now[1];
        res.servo_2 = angle_now[2];
        res.servo_3 = angle_now[3];
        res.pot_0   = sat[0];
        res.pot_1   = sat[1];
        res.pot_2   = sat[2];
        res.pot_3   = sat[3];
        res.soft_start_active = ramp_active;
        pending_setpoints.push_back(res);
      end
      default: ;
    endcase
  endtask

  // ---------------------------------------------------------------------------
  // Result checking
  // ---------------------------------------------------------------------------

  task automatic check_field(input string field, input logic [9:0] exp_val,
                             input logic [9:0] act_val);
    if (exp_val !== act_val) begin
      $error("%s: expected %0d, got %0d", field, exp_val, act_val);
      fail_count++;
    end
  endtask

  // Compare every item taken from the output with the oldest expectation
  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) begin
      if (pending_setpoints.size() == 0) begin
        $error("result item arrived with no tick outstanding");
        fail_count++;
      end else begin
        want = pending_setpoints.pop_front();
        check_field("servo_0", want.servo_0, out_data.servo_0);
        check_field("servo_1", want.servo_1, out_data.servo_1);
        check_field("servo_2", want.servo_2, out_data.servo_2);
        check_field("servo_3", want.servo_3, out_data.servo_3);
        check_field("pot_0", want.pot_0, out_data.pot_0);
        check_field("pot_1", want.pot_1, out_data.pot_1);
        check_field("pot_2", want.pot_2, out_data.pot_2);
        check_field("pot_3", want.pot_3, out_data.pot_3);
        check_field("soft_start_active", want.soft_start_active,
                    out_data.soft_start_active);
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Item builders and random values
  // ---------------------------------------------------------------------------

  // Fill every field with noise; builders then overwrite what matters
  function automatic ssg_in_t junk_item();
    logic [159:0] bits;
    bits = {$urandom(), $urandom(), $urandom(), $urandom(), $urandom()};
    return bits[$bits(ssg_in_t)-1:0];
  endfunction

  function automatic ssg_in_t tick_item(input logic [15:0] p0, input logic [15:0] p1,
                                        input logic [15:0] p2, input logic [15:0] p3);
    ssg_in_t item;
    item = junk_item();
    item.command   = CMD_TICK;
    item.pot_raw_0 = p0;
    item.pot_raw_1 = p1;
    item.pot_raw_2 = p2;
    item.pot_raw_3 = p3;
    return item;
  endfunction

  function automatic ssg_in_t pad_item(input logic [15:0] a0, input logic [15:0] a1,
                                       input logic [15:0] a2, input logic [15:0] a3);
    ssg_in_t item;
    item = junk_item();
    item.command = CMD_PAD;
    item.pad_0   = a0;
    item.pad_1   = a1;
    item.pad_2   = a2;
    item.pad_3   = a3;
    return item;
  endfunction

  function automatic ssg_in_t mode_item(input logic [7:0] value);
    ssg_in_t item;
    item = junk_item();
    item.command    = CMD_MODE;
    item.mode_value = value;
    return item;
  endfunction

  function automatic ssg_in_t unused_item();
    ssg_in_t item;
    item = junk_item();
    item.command = CMD_UNUSED;
    return item;
  endfunction

  // Favor the saturation edges, keep the full 16-bit range in play
  function automatic logic [15:0] rand_pot();
    case ($urandom_range(9))
      0:       return 16'd0;
      1:       return 16'd1023;
      2:       return 16'd1024;
      3:       return 16'hFFFF;
      4, 5, 6: return 16'($urandom_range(1023));
      default: return 16'($urandom());
    endcase
  endfunction

  // Mix full-scale axes with small ones that build up fractions
  function automatic logic [15:0] rand_pad();
    case ($urandom_range(9))
      0:       return 16'h7FFF;
      1:       return 16'h8000;
      2:       return 16'h0000;
      3, 4, 5: return 16'($urandom_range(800)) - 16'd400;
      default: return 16'($urandom());
    endcase
  endfunction

  function automatic logic [7:0] rand_angle();
    case ($urandom_range(9))
      0:       return 8'd0;
      1:       return 8'd180;
      2:       return 8'd255;
      3:       return 8'($urandom_range(181, 255));
      default: return 8'($urandom_range(180));
    endcase
  endfunction

  function automatic ssg_in_t rand_tick();
    return tick_item(rand_pot(), rand_pot(), rand_pot(), rand_pot());
  endfunction

  function automatic ssg_in_t rand_pad_item();
    return pad_item(rand_pad(), rand_pad(), rand_pad(), rand_pad());
  endfunction

  // ---------------------------------------------------------------------------
  // Drivers
  // ---------------------------------------------------------------------------

  // Offer one item; called at a falling edge, returns at the falling edge after
  // acceptance. Valid stays up so back-to-back items follow without a gap.
  task automatic send_item(input ssg_in_t item);
    while ($urandom_range(99) < send_gap_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= item;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    advance_setpoint_model(item);
    @(negedge clk);
  endtask

  // Drop valid and hold until every owed result has come back
  task automatic wait_results_drained();
    in_valid <= 1'b0;
    while (pending_setpoints.size() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  // One APB write: setup phase, access phase, then an idle phase with psel low so writes can follow
  task automatic apb_write(input logic bank, input int servo, input logic [7:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {bank, 2'(servo), 2'b00};
    pwdata  <= {24'($urandom()), value};
    @(negedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    if (bank == BANK_MIN) cfg_lo[servo] = value;
    else cfg_hi[servo] = value;
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(negedge clk);
  endtask

  task automatic randomize_angles();
    for (int s = 0; s < 4; s++) begin
      apb_write(BANK_MIN, s, rand_angle());
      apb_write(BANK_MAX, s, rand_angle());
    end
  endtask

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Pot words around and far above the saturation point, default angle pairs
  task automatic test_pot_saturation();
    send_gap_pct = 0;
    stall_pct    = 0;
    send_item(tick_item(16'd0, 16'd0, 16'd0, 16'd0));
    send_item(tick_item(16'd1023, 16'd1023, 16'd1023, 16'd1023));
    send_item(tick_item(16'd1024, 16'hFFFF, 16'd1024, 16'hFFFF));
    send_item(tick_item(16'hFFFF, 16'd1024, 16'h8000, 16'h03FF));
    send_item(tick_item(16'd512, 16'd1, 16'd1022, 16'h7FFF));
  endtask

  // Unused code, unlisted modes, gamepad extremes, remote mode and the restart
  task automatic test_command_codes();
    send_item(unused_item());
    send_item(mode_item(8'd2));
    send_item(mode_item(8'd255));
    send_item(pad_item(16'h7FFF, 16'h8000, 16'hFFFF, 16'h0000));
    send_item(mode_item(MODE_REMOTE));
    repeat (3) send_item(tick_item(16'd0, 16'd1023, 16'hFFFF, 16'd7));
    send_item(pad_item(16'h8000, 16'h7FFF, 16'h0001, 16'hFFFF));
    repeat (2) send_item(tick_item(16'd1023, 16'd0, 16'd100, 16'd900));
    send_item(mode_item(MODE_MANUAL));
    repeat (2) send_item(tick_item(16'd300, 16'd700, 16'd1023, 16'd0));
  endtask

  // Reversed, equal and out-of-range angle pairs in both modes
  task automatic test_register_extremes();
    wait_results_drained();
    apb_write(BANK_MIN, 0, 8'd0);
    apb_write(BANK_MAX, 0, 8'd255);
    apb_write(BANK_MIN, 1, 8'd255);
    apb_write(BANK_MAX, 1, 8'd0);
    apb_write(BANK_MIN, 2, 8'd180);
    apb_write(BANK_MAX, 2, 8'd180);
    apb_write(BANK_MIN, 3, 8'd255);
    apb_write(BANK_MAX, 3, 8'd255);
    send_item(tick_item(16'd1023, 16'd1023, 16'd1023, 16'd1023));
    send_item(tick_item(16'd0, 16'd0, 16'd0, 16'd0));
    send_item(pad_item(16'h7FFF, 16'h7FFF, 16'h8000, 16'h8000));
    send_item(mode_item(MODE_REMOTE));
    repeat (2) send_item(tick_item(16'd511, 16'd512, 16'd0, 16'd1023));
    send_item(mode_item(MODE_MANUAL));
  endtask

  // Linear mapping across random angle pairs; the first ramp runs out here
  task automatic test_manual_mapping();
    int pick;
    send_gap_pct = 0;
    stall_pct    = 0;
    wait_results_drained();
    randomize_angles();
    for (int n = 0; n < 280; n++) begin
      pick = $urandom_range(99);
      if (pick < 4) send_item(unused_item());
      else if (pick < 7) send_item(mode_item(8'($urandom_range(2, 255))));
      else if (pick < 10) send_item(rand_pad_item());
      else send_item(rand_tick());
    end
  endtask

  // Gamepad runs in remote mode with clamping, rare restarts; sender idles
  task automatic test_remote_tracking();
    int sent;
    send_gap_pct = 63;
    stall_pct    = 0;
    wait_results_drained();
    randomize_angles();
    send_item(mode_item(MODE_REMOTE));
    sent = 1;
    while (sent < 320) begin
      if ($urandom_range(49) == 0) begin
        send_item(mode_item(MODE_MANUAL));
        send_item(mode_item(MODE_REMOTE));
        sent += 2;
      end
      send_item(rand_pad_item());
      sent++;
      repeat ($urandom_range(1, 8)) begin
        send_item(rand_tick());
        sent++;
      end
    end
  endtask

  // Ramps from a restart, running up to or past the end of soft start; receiver stalls
  task automatic test_soft_start_restart();
    int run;
    send_gap_pct = 0;
    stall_pct    = 63;
    repeat (2) begin
      wait_results_drained();
      randomize_angles();
      send_item(mode_item(MODE_MANUAL));
      if ($urandom_range(1)) send_item(mode_item(MODE_REMOTE));
      run = $urandom_range(175, 200);
      for (int n = 0; n < run; n++) begin
        if ($urandom_range(19) == 0) send_item(rand_pad_item());
        else send_item(rand_tick());
      end
    end
  endtask

  // Everything mixed, both sides idling, with pauses until all results are in
  task automatic test_mixed_noise();
    int pick;
    send_gap_pct = 29;
    stall_pct    = 29;
    wait_results_drained();
    randomize_angles();
    for (int n = 0; n < 280; n++) begin
      if (n == 140) begin
        wait_results_drained();
        randomize_angles();
      end else if (n % 60 == 59) begin
        wait_results_drained();
      end
      pick = $urandom_range(99);
      if (pick < 50) begin
        send_item(rand_tick());
      end else if (pick < 65) begin
        send_item(rand_pad_item());
      end else if (pick < 80) begin
        case ($urandom_range(9))
          0:       send_item(mode_item(MODE_MANUAL));
          1, 2, 3: send_item(mode_item(MODE_REMOTE));
          default: send_item(mode_item(8'($urandom())));
        endcase
      end else if (pick < 85) begin
        send_item(unused_item());
      end else begin
        send_item(rand_tick());
      end
    end
  endtask

  // ---------------------------------------------------------------------------
  // Sequence
  // ---------------------------------------------------------------------------

  initial begin
    reset_setpoint_model();
    repeat (12) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);
    test_pot_saturation();
    test_command_codes();
    test_register_extremes();
    test_manual_mapping();
    test_remote_tracking();
    test_soft_start_restart();
    test_mixed_noise();
    wait_results_drained();
    if (fail_count == 0) begin
      $display("servo_setpoint_generator_core: match");
    end else begin
      $display("servo_setpoint_generator_core: mismatch");
    end
    $finish;
  end

  // Watchdog: far beyond the slowest correct run
  initial begin
    #2000000;
    $display("servo_setpoint_generator_core: mismatch");
    $finish;
  end

endmodule

/* sim.f */
sv/ssg_pkg.sv
sv/servo_setpoint_generator_core.sv
tb/servo_setpoint_generator_core_tb.sv
